[design/sgdu_pkg.sv]
// shared types, command codes and size defaults for the sgd layer update core
package sgdu_pkg;

	localparam int NEURONS_DEF = 16;
	localparam int INPUTS_DEF  = 16;

	localparam int DATA_W  = 16;
	localparam int ACC_W   = 48;
	localparam int RATE_W  = 16;
	localparam int BATCH_W = 11;
	localparam int DIV_W   = 63;
	localparam int CFG_IDX_W = 2;

	localparam logic [2:0] CMD_WR_WEIGHT = 3'd0;
	localparam logic [2:0] CMD_WR_BIAS   = 3'd1;
	localparam logic [2:0] CMD_LOAD_IN   = 3'd2;
	localparam logic [2:0] CMD_ADD_ERR   = 3'd3;
	localparam logic [2:0] CMD_APPLY     = 3'd4;
	localparam logic [2:0] CMD_RD_WEIGHT = 3'd5;
	localparam logic [2:0] CMD_RD_BIAS   = 3'd6;

	localparam logic [CFG_IDX_W-1:0] REG_RATE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BATCH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY = 2'd2;

	localparam logic [RATE_W-1:0]  RATE_RST  = 16'd655;
	localparam logic [BATCH_W-1:0] BATCH_RST = 11'd32;
	localparam logic [RATE_W-1:0]  DECAY_RST = 16'd0;

	typedef struct packed {
		logic [2:0]               cmd;
		logic [3:0]               row_index;
		logic [3:0]               col_index;
		logic signed [DATA_W-1:0] data_value;
	} sgdu_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic                     saturated;
	} sgdu_out_t;

endpackage

[design/sgd_layer_weight_update_core.sv]
// sgd gradient step core for one dense layer, q4.12 weights and 48-bit accumulators
// apply update walks every weight and bias, NEURONS*(INPUTS+1) of them, one at a time,
//   each through a bit-serial divide by the batch count
// one transaction at a time; the next is taken only once the result has left or is leaving
// reset: async active low; then a clearing pass over all NEURONS*(INPUTS+1) addresses zeroes
//   the value and accumulator memories before the first transaction is taken
module sgd_layer_weight_update_core #(
	parameter int NEURONS = sgdu_pkg::NEURONS_DEF,
	parameter int INPUTS  = sgdu_pkg::INPUTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	output logic                              cmd_ready,
	input  sgdu_pkg::sgdu_in_t                cmd_data,
	output logic                              res_valid,
	input  logic                              res_ready,
	output sgdu_pkg::sgdu_out_t               res_data,
	input  logic                              cfg_write_en,
	input  logic [sgdu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sgdu_pkg::RATE_W-1:0]       cfg_wdata
);
	import sgdu_pkg::*;

	// weights at 0..WCOUNT-1 row major, biases after them
	localparam int WCOUNT = NEURONS * INPUTS;
	localparam int DEPTH  = WCOUNT + NEURONS;
	localparam int AW     = $clog2(DEPTH);
	localparam int CW     = $clog2(INPUTS + 1);

	localparam logic [3:0] S_CLEAR   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_RDW     = 4'd2;
	localparam logic [3:0] S_ERR     = 4'd3;
	localparam logic [3:0] S_ERR_END = 4'd4;
	localparam logic [3:0] S_URD     = 4'd5;
	localparam logic [3:0] S_UCAP    = 4'd6;
	localparam logic [3:0] S_UDIVS   = 4'd7;
	localparam logic [3:0] S_UDIV    = 4'd8;
	localparam logic [3:0] S_USUM    = 4'd9;
	localparam logic [3:0] S_UWB     = 4'd10;

	logic [3:0] state_q;

	// configuration
	logic [RATE_W-1:0]  rate_q;
	logic [BATCH_W-1:0] batch_q;
	logic [RATE_W-1:0]  decay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q  <= RATE_RST;
			batch_q <= BATCH_RST;
			decay_q <= DECAY_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_RATE:  rate_q  <= cfg_wdata;
				REG_BATCH: batch_q <= cfg_wdata[BATCH_W-1:0];
				REG_DECAY: decay_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input side decode
	logic          accept;
	logic          row_ok;
	logic          col_ok;
	logic [AW-1:0] row_base;
	logic [AW-1:0] w_addr_in;
	logic [AW-1:0] b_addr_in;

	assign cmd_ready = (state_q == S_IDLE) && (!res_valid || res_ready);
	assign accept    = cmd_valid && cmd_ready;
	assign row_ok    = 32'(cmd_data.row_index) < NEURONS;
	assign col_ok    = 32'(cmd_data.col_index) < INPUTS;
	assign row_base  = AW'(32'(cmd_data.row_index) * INPUTS);
	assign w_addr_in = row_base + AW'(cmd_data.col_index);
	assign b_addr_in = AW'(WCOUNT) + AW'(cmd_data.row_index);

	// sample input ring: cell 0 is the head, cells rotate toward it during add error
	logic                     ring_shift;
	logic signed [DATA_W-1:0] ring_val [INPUTS];

	for (genvar gi = 0; gi < INPUTS; gi++) begin : g_ring
		sgdu_input_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.load_en   (accept && cmd_data.cmd == CMD_LOAD_IN && col_ok &&
			            32'(cmd_data.col_index) == gi),
			.load_data (cmd_data.data_value),
			.shift_en  (ring_shift),
			.shift_in  (ring_val[(gi + 1) % INPUTS]),
			.value     (ring_val[gi])
		);
	end

	// memories: values and gradient accumulators share one address map
	logic                    val_we;
	logic [AW-1:0]           val_waddr;
	logic [DATA_W-1:0]       val_wdata;
	logic [DATA_W-1:0]       val_rdata;
	logic                    acc_we;
	logic [AW-1:0]           acc_waddr;
	logic [ACC_W-1:0]        acc_wdata;
	logic [ACC_W-1:0]        acc_rdata;
	logic [AW-1:0]           raddr;

	sgdu_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_wdata),
		.raddr (raddr),
		.rdata (val_rdata)
	);

	sgdu_ram #(.WIDTH(ACC_W), .DEPTH(DEPTH)) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (acc_wdata),
		.raddr (raddr),
		.rdata (acc_rdata)
	);

	// working registers
	logic [AW-1:0]            addr_q;
	logic [AW-1:0]            row_base_q;
	logic [AW-1:0]            bias_addr_q;
	logic [CW-1:0]            col_q;
	logic signed [DATA_W-1:0] err_q;
	logic                     rd_ok_q;
	logic                     sat_q;

	// add error pipeline: read issued, then multiply-accumulate and write back
	logic                     err_v_s1;
	logic [AW-1:0]            err_addr_s1;
	logic signed [DATA_W-1:0] err_op_s1;
	logic                     err_issue;
	logic                     err_col_step;
	logic [AW-1:0]            err_addr;
	logic signed [ACC_W-1:0]  err_sum;

	assign err_issue    = state_q == S_ERR;
	assign err_col_step = err_issue && (col_q < CW'(INPUTS));
	assign err_addr     = err_col_step ? (row_base_q + AW'(col_q)) : bias_addr_q;
	assign ring_shift   = err_col_step;
	// the bias gradient takes the error times one in q.12
	assign err_sum      = $signed(acc_rdata) +
	                      ACC_W'($signed(err_q) * $signed(err_op_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_v_s1 <= 1'b0;
		end else begin
			err_v_s1 <= err_issue;
		end
	end

	always_ff @(posedge clk) begin
		err_addr_s1 <= err_addr;
		err_op_s1   <= err_col_step ? ring_val[0] : DATA_W'(16'sd4096);
	end

	// update datapath
	logic signed [63:0]       prod_q;
	logic signed [32:0]       decay_prod_q;
	logic signed [DATA_W-1:0] cur_val_q;
	logic                     neg_q;
	logic signed [63:0]       t1_q;
	logic signed [37:0]       delta_q;
	logic                     div_start;
	logic                     div_done;
	logic [DIV_W-1:0]         div_quot;
	logic [63:0]              prod_mag;
	logic [BATCH_W-1:0]       divisor;
	logic signed [65:0]       upd_sum;
	logic signed [38:0]       new_val;
	logic signed [DATA_W-1:0] new_val_sat;
	logic                     new_clip;

	assign div_start = state_q == S_UDIVS;
	assign prod_mag  = prod_q[63] ? (64'd0 - prod_q) : prod_q;
	// a batch count of zero acts as one
	assign divisor   = (batch_q == '0) ? BATCH_W'(1) : batch_q;

	sgdu_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_mag[DIV_W-1:0]),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// delta = floor((t1 + decay*value*4096 + 2^27) / 2^28)
	assign upd_sum = 66'(t1_q) + (66'(decay_prod_q) <<< 12) + 66'(64'sd134217728);
	assign new_val = 39'(cur_val_q) - 39'(delta_q);

	always_comb begin
		new_clip    = 1'b0;
		new_val_sat = new_val[DATA_W-1:0];
		if (new_val > 39'sd32767) begin
			new_clip    = 1'b1;
			new_val_sat = DATA_W'(16'sh7fff);
		end else if (new_val < -39'sd32768) begin
			new_clip    = 1'b1;
			new_val_sat = DATA_W'(16'sh8000);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_UCAP) begin
			cur_val_q    <= val_rdata;
			prod_q       <= 64'($signed(acc_rdata) * $signed({1'b0, rate_q}));
			decay_prod_q <= $signed(val_rdata) * $signed({1'b0, decay_q});
		end
		if (state_q == S_UDIVS) begin
			neg_q <= prod_q[63];
		end
		if (div_done) begin
			t1_q <= neg_q ? (64'sd0 - $signed({1'b0, div_quot})) : $signed({1'b0, div_quot});
		end
		if (state_q == S_USUM) begin
			delta_q <= upd_sum[65:28];
		end
	end

	// shared read address
	always_comb begin
		raddr = addr_q;
		if (state_q == S_IDLE) begin
			raddr = (cmd_data.cmd == CMD_RD_BIAS) ? b_addr_in : w_addr_in;
		end else if (err_issue) begin
			raddr = err_addr;
		end
	end

	// write ports
	always_comb begin
		val_we    = 1'b0;
		val_waddr = addr_q;
		val_wdata = '0;
		acc_we    = 1'b0;
		acc_waddr = addr_q;
		acc_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				val_we = 1'b1;
				acc_we = 1'b1;
			end
			S_IDLE: begin
				if (accept && cmd_data.cmd == CMD_WR_WEIGHT && row_ok && col_ok) begin
					val_we    = 1'b1;
					val_waddr = w_addr_in;
					val_wdata = cmd_data.data_value;
				end else if (accept && cmd_data.cmd == CMD_WR_BIAS && row_ok) begin
					val_we    = 1'b1;
					val_waddr = b_addr_in;
					val_wdata = cmd_data.data_value;
				end
			end
			S_UWB: begin
				val_we    = 1'b1;
				val_wdata = new_val_sat;
				acc_we    = 1'b1;
			end
			default: ;
		endcase
		if (err_v_s1) begin
			acc_we    = 1'b1;
			acc_waddr = err_addr_s1;
			acc_wdata = err_sum;
		end
	end

	// result register
	logic      res_valid_q;
	sgdu_out_t res_q;

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			addr_q      <= '0;
			col_q       <= '0;
			res_valid_q <= 1'b0;
			sat_q       <= 1'b0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (cmd_data.cmd) inside
							CMD_RD_WEIGHT, CMD_RD_BIAS: begin
								state_q <= S_RDW;
							end
							CMD_ADD_ERR: begin
								if (row_ok) begin
									state_q <= S_ERR;
									col_q   <= '0;
								end else begin
									res_valid_q <= 1'b1;
								end
							end
							CMD_APPLY: begin
								state_q <= S_URD;
								addr_q  <= '0;
								sat_q   <= 1'b0;
							end
							default: begin
								res_valid_q <= 1'b1;
							end
						endcase
					end
				end
				S_RDW: begin
					res_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_ERR: begin
					if (err_col_step) begin
						col_q <= col_q + 1'b1;
					end else begin
						state_q <= S_ERR_END;
					end
				end
				S_ERR_END: begin
					res_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_URD:   state_q <= S_UCAP;
				S_UCAP:  state_q <= S_UDIVS;
				S_UDIVS: state_q <= S_UDIV;
				S_UDIV: begin
					if (div_done) begin
						state_q <= S_USUM;
					end
				end
				S_USUM:  state_q <= S_UWB;
				S_UWB: begin
					sat_q <= sat_q | new_clip;
					if (addr_q == AW'(DEPTH - 1)) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						addr_q  <= addr_q + 1'b1;
						state_q <= S_URD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload side of the result and the per-transaction context
	always_ff @(posedge clk) begin
		if (accept) begin
			row_base_q  <= row_base;
			bias_addr_q <= b_addr_in;
			err_q       <= cmd_data.data_value;
			rd_ok_q     <= (cmd_data.cmd == CMD_RD_WEIGHT) ? (row_ok && col_ok) : row_ok;
			res_q       <= '0;
		end
		if (state_q == S_RDW) begin
			res_q.read_value <= rd_ok_q ? $signed(val_rdata) : '0;
			res_q.saturated  <= 1'b0;
		end
		if (state_q == S_UWB && addr_q == AW'(DEPTH - 1)) begin
			res_q.read_value <= '0;
			res_q.saturated  <= sat_q | new_clip;
		end
	end

	// checks
	a_no_take_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !cmd_ready)
		else $error("transaction taken while the core is busy");

	a_err_wb_follows_issue: assert property (@(posedge clk) disable iff (!arst_n)
		err_v_s1 |-> $past(state_q == S_ERR))
		else $error("accumulator write back without an issued read");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_UDIV))
		else $error("divider finished outside the update wait");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q == S_IDLE) || $past(state_q == S_RDW) ||
		$past(state_q == S_ERR_END) || $past(state_q == S_UWB)))
		else $error("result raised from an unexpected state");

endmodule

[design/sgdu_ram.sv]
// generic single write port ram with registered read
module sgdu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 272
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[design/sgdu_input_cell.sv]
// one cell of the sample input ring: holds one input, loads or takes its neighbor
module sgdu_input_cell (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load_en,
	input  logic signed [sgdu_pkg::DATA_W-1:0]   load_data,
	input  logic                                 shift_en,
	input  logic signed [sgdu_pkg::DATA_W-1:0]   shift_in,
	output logic signed [sgdu_pkg::DATA_W-1:0]   value
);
	import sgdu_pkg::*;

	logic signed [DATA_W-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (shift_en) begin
			value_q <= shift_in;
		end else if (load_en) begin
			value_q <= load_data;
		end
	end

	assign value = value_q;
endmodule

[design/sgdu_divider.sv]
// restoring unsigned divider, one quotient bit per cycle
module sgdu_divider (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [sgdu_pkg::DIV_W-1:0]       dividend,
	input  logic [sgdu_pkg::BATCH_W-1:0]     divisor,
	output logic                             done,
	output logic [sgdu_pkg::DIV_W-1:0]       quotient
);
	import sgdu_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DIV_W-1:0]   num_q;
	logic [BATCH_W-1:0] rem_q;
	logic [BATCH_W-1:0] div_q;
	logic [BATCH_W:0]   trial;
	logic               qbit;
	logic [BATCH_W:0]   diff;

	always_comb begin
		trial = {rem_q, num_q[DIV_W-1]};
		qbit  = trial >= {1'b0, div_q};
		diff  = qbit ? (trial - {1'b0, div_q}) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_W-2:0], qbit};
			rem_q <= diff[BATCH_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = num_q;
endmodule

[verif/sgdu_checker.sv]
// checker for the sgd layer update core: watches both channels, predicts and compares
module sgdu_checker #(
	parameter int NEURONS = sgdu_pkg::NEURONS_DEF,
	parameter int INPUTS  = sgdu_pkg::INPUTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	input  logic                           cmd_ready,
	input  sgdu_pkg::sgdu_in_t             cmd_data,
	input  logic                           res_valid,
	input  logic                           res_ready,
	input  sgdu_pkg::sgdu_out_t            res_data,
	input  logic                           cfg_write_en,
	input  logic [sgdu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sgdu_pkg::RATE_W-1:0]    cfg_wdata,
	output int                             pending,
	output int                             fail_count
);
	import sgdu_pkg::*;

	logic signed [DATA_W-1:0] layer_weights [NEURONS*INPUTS];
	logic signed [DATA_W-1:0] layer_biases  [NEURONS];
	logic [ACC_W-1:0]         weight_grads  [NEURONS*INPUTS];
	logic [ACC_W-1:0]         bias_grads    [NEURONS];
	logic signed [DATA_W-1:0] sample_vec    [INPUTS];
	logic [RATE_W-1:0]        rate;
	logic [BATCH_W-1:0]       batch;
	logic [RATE_W-1:0]        decay;
	sgdu_out_t                expected_results [$];

	// one value after the step, clipped to q4.12
	function automatic logic signed [DATA_W-1:0] stepped_value(
		input logic signed [DATA_W-1:0] v, input logic [ACC_W-1:0] acc, inout logic clip);
		longint grad, t1, t2, delta, nv, div;
		grad  = longint'($signed(acc));
		div   = (batch == 0) ? 64'sd1 : longint'(batch);
		t1    = (grad * longint'(rate)) / div;
		t2    = longint'(v) * longint'(decay) * 64'sd4096;
		delta = (t1 + t2 + (64'sd1 <<< 27)) >>> 28;
		nv    = longint'(v) - delta;
		if (nv > 32767) begin
			clip = 1'b1;
			return 16'sh7fff;
		end
		if (nv < -32768) begin
			clip = 1'b1;
			return 16'sh8000;
		end
		return nv[DATA_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sgdu_out_t exp_res;
		int        k;
		if (!arst_n) begin
			foreach (layer_weights[i]) layer_weights[i] = '0;
			foreach (layer_biases[i]) layer_biases[i] = '0;
			foreach (weight_grads[i]) weight_grads[i] = '0;
			foreach (bias_grads[i]) bias_grads[i] = '0;
			foreach (sample_vec[i]) sample_vec[i] = '0;
			rate  = RATE_RST;
			batch = BATCH_RST;
			decay = DECAY_RST;
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					REG_RATE:  rate  = cfg_wdata;
					REG_BATCH: batch = cfg_wdata[BATCH_W-1:0];
					REG_DECAY: decay = cfg_wdata;
					default: ;
				endcase
			end
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with no expectation waiting");
					fail_count++;
				end else begin
					exp_res = expected_results.pop_front();
					if (res_data.read_value !== exp_res.read_value) begin
						$error("read_value: expected %0d, actual %0d",
							exp_res.read_value, res_data.read_value);
						fail_count++;
					end
					if (res_data.saturated !== exp_res.saturated) begin
						$error("saturated: expected %0d, actual %0d",
							exp_res.saturated, res_data.saturated);
						fail_count++;
					end
				end
			end
			if (cmd_valid && cmd_ready) begin
				exp_res = '0;
				k = cmd_data.row_index * INPUTS + cmd_data.col_index;
				case (cmd_data.cmd)
					CMD_WR_WEIGHT: layer_weights[k] = cmd_data.data_value;
					CMD_WR_BIAS:   layer_biases[cmd_data.row_index] = cmd_data.data_value;
					CMD_LOAD_IN:   sample_vec[cmd_data.col_index] = cmd_data.data_value;
					CMD_ADD_ERR: begin
						for (int c = 0; c < INPUTS; c++)
							weight_grads[cmd_data.row_index*INPUTS+c] += ACC_W'(
								longint'(cmd_data.data_value) * longint'(sample_vec[c]));
						bias_grads[cmd_data.row_index] +=
							ACC_W'(longint'(cmd_data.data_value) * 64'sd4096);
					end
					CMD_APPLY: begin
						for (int i = 0; i < NEURONS*INPUTS; i++) begin
							layer_weights[i] = stepped_value(layer_weights[i],
								weight_grads[i], exp_res.saturated);
							weight_grads[i] = '0;
						end
						for (int i = 0; i < NEURONS; i++) begin
							layer_biases[i] = stepped_value(layer_biases[i],
								bias_grads[i], exp_res.saturated);
							bias_grads[i] = '0;
						end
					end
					CMD_RD_WEIGHT: exp_res.read_value = layer_weights[k];
					CMD_RD_BIAS:   exp_res.read_value = layer_biases[cmd_data.row_index];
					default: ;
				endcase
				expected_results.push_back(exp_res);
			end
		end
		pending = expected_results.size();
	end

endmodule

[verif/tb_sgd_layer_weight_update_core.sv]
// testbench top for the sgd layer update core: stimulus, idling phases and verdict
module tb_sgd_layer_weight_update_core;
	import sgdu_pkg::*;

	localparam int WATCHDOG_LIMIT = 400000;

	logic                 clk;
	logic                 arst_n;
	logic                 cmd_valid;
	logic                 cmd_ready;
	sgdu_in_t             cmd_data;
	logic                 res_valid;
	logic                 res_ready;
	sgdu_out_t            res_data;
	logic                 cfg_write_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [RATE_W-1:0]    cfg_wdata;
	int                   pending;
	int                   fail_count;

	// idling knobs, percent of cycles
	int sender_idle_pct;
	int receiver_stall_pct;
	// long receiver hold-off request, served in the receiver process
	logic hold_res;
	int   quiet_cycles;

	sgd_layer_weight_update_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd_data    (cmd_data),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_data    (res_data),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	sgdu_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd_data    (cmd_data),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_data    (res_data),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.pending     (pending),
		.fail_count  (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: random stalls, plus a counted long hold-off on request
	initial begin
		int held;
		res_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_res) begin
				res_ready <= 1'b0;
				held = 0;
				while (held < 400) begin
					@(posedge clk);
					held++;
				end
				hold_res  = 1'b0;
				res_ready <= 1'b1;
			end else begin
				res_ready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	// watchdog: cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// offer one transaction, hold it until taken, then maybe idle a while
	task automatic send_cmd(input logic [2:0] op, input logic [3:0] row,
		input logic [3:0] col, input logic [15:0] val);
		cmd_valid <= 1'b1;
		cmd_data  <= '{cmd: op, row_index: row, col_index: col, data_value: val};
		do @(posedge clk); while (!cmd_ready);
		if ($urandom_range(99) < sender_idle_pct) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
	endtask

	// lower valid and wait for every expected result, then let the bench settle
	task automatic drain;
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// the enable stays high between back to back writes; set_cfg lowers it
	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_wdata    <= val;
		@(posedge clk);
	endtask

	task automatic set_cfg(input logic [RATE_W-1:0] lr, input logic [RATE_W-1:0] bc,
		input logic [RATE_W-1:0] dk);
		write_cfg(REG_RATE, lr);
		write_cfg(REG_BATCH, bc);
		write_cfg(REG_DECAY, dk);
		cfg_write_en <= 1'b0;
	endtask

	// one random transaction; updates are rare since each walks the whole layer
	task automatic random_cmd(output bit counted);
		int          pick;
		logic [2:0]  op;
		pick = $urandom_range(999);
		if (pick < 100)      op = CMD_WR_WEIGHT;
		else if (pick < 160) op = CMD_WR_BIAS;
		else if (pick < 370) op = CMD_LOAD_IN;
		else if (pick < 660) op = CMD_ADD_ERR;
		else if (pick < 670) op = CMD_APPLY;
		else if (pick < 840) op = CMD_RD_WEIGHT;
		else if (pick < 960) op = CMD_RD_BIAS;
		else                 op = 3'd7;
		counted = (op != 3'd7);
		send_cmd(op, 4'($urandom), 4'($urandom), 16'($urandom));
	endtask

	initial begin
		bit counted;
		int sent;
		arst_n             = 1'b0;
		cmd_valid          = 1'b0;
		cmd_data           = '0;
		cfg_write_en       = 1'b0;
		cfg_index          = '0;
		cfg_wdata          = '0;
		hold_res           = 1'b0;
		quiet_cycles       = 0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reads of reset state, field extremes, every command
		send_cmd(CMD_RD_WEIGHT, 4'd15, 4'd15, 16'h0000);
		send_cmd(CMD_RD_BIAS, 4'd0, 4'd0, 16'h0000);
		send_cmd(CMD_WR_WEIGHT, 4'd0, 4'd0, 16'h7fff);
		send_cmd(CMD_WR_WEIGHT, 4'd15, 4'd15, 16'h8000);
		send_cmd(CMD_WR_BIAS, 4'd15, 4'd0, 16'h8000);
		send_cmd(CMD_WR_BIAS, 4'd0, 4'd15, 16'h7fff);
		send_cmd(CMD_LOAD_IN, 4'd0, 4'd0, 16'h7fff);
		send_cmd(CMD_LOAD_IN, 4'd3, 4'd15, 16'h8000);
		send_cmd(CMD_ADD_ERR, 4'd0, 4'd0, 16'h7fff);
		send_cmd(CMD_ADD_ERR, 4'd15, 4'd9, 16'h8000);
		send_cmd(3'd7, 4'd5, 4'd5, 16'hffff);
		send_cmd(CMD_APPLY, 4'd0, 4'd0, 16'h0000);
		send_cmd(CMD_RD_WEIGHT, 4'd0, 4'd0, 16'h0000);
		send_cmd(CMD_RD_WEIGHT, 4'd15, 4'd15, 16'h0000);
		send_cmd(CMD_RD_BIAS, 4'd15, 4'd0, 16'h0000);
		send_cmd(CMD_RD_BIAS, 4'd0, 4'd0, 16'h0000);
		drain();

		// extreme settings: biggest rate, smallest batch, full decay to force clipping
		set_cfg(16'hffff, 16'd1, 16'hffff);
		send_cmd(CMD_LOAD_IN, 4'd0, 4'd1, 16'h7fff);
		send_cmd(CMD_ADD_ERR, 4'd2, 4'd0, 16'h7fff);
		send_cmd(CMD_ADD_ERR, 4'd2, 4'd0, 16'h7fff);
		send_cmd(CMD_APPLY, 4'd0, 4'd0, 16'h0000);
		send_cmd(CMD_RD_WEIGHT, 4'd2, 4'd1, 16'h0000);
		send_cmd(CMD_RD_BIAS, 4'd2, 4'd0, 16'h0000);
		drain();

		sent = 0;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					set_cfg(16'd0, 16'd0, 16'd0);   // zero batch acts as one
					sender_idle_pct    = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					set_cfg(16'd1000, 16'd1024, 16'd3);
					sender_idle_pct    = 71;
					receiver_stall_pct = 0;
				end
				2: begin
					set_cfg(16'h8000, 16'd2047, 16'd65535);
					sender_idle_pct    = 0;
					receiver_stall_pct = 71;
				end
				default: begin
					set_cfg(16'd655, 16'd32, 16'd0);
					sender_idle_pct    = 23;
					receiver_stall_pct = 23;
				end
			endcase
			// long receiver hold-off while the sender keeps offering
			if (phase == 1) hold_res = 1'b1;
			while (sent < (phase + 1) * 450) begin
				random_cmd(counted);
				if (counted) sent++;
				// sender pause until every result is back
				if (phase == 2 && sent == 2 * 450 + 200) drain();
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
